// File: rtl/rae_pkg.sv
// Package for the RESP array argument extractor: character codes, parser
// phases, the result word type and queue sizing. No dependencies.
package rae_pkg;

	localparam int LEN_BITS_DEF = 20;

	// queue between parser and output stage; depth must be a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LF     = 8'h0A;

	typedef enum logic [8:0] {
		PH_STAR    = 9'b000000001,
		PH_HEADER  = 9'b000000010,
		PH_DOLLAR  = 9'b000000100,
		PH_DIGITS  = 9'b000001000,
		PH_SKIP    = 9'b000010000,
		PH_PAYLOAD = 9'b000100000,
		PH_TRAIL1  = 9'b001000000,
		PH_TRAIL2  = 9'b010000000,
		PH_IDLE    = 9'b100000000
	} rae_phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] arg_index;
		logic       last_in_arg;
		logic       empty_arg;
		logic       truncated;
	} rae_word_t;

	typedef struct packed {
		logic      valid;
		rae_word_t word;
	} rae_push_t;

endpackage

// File: rtl/rae_if.sv
// Channel interfaces of the argument extractor: request bytes in, argument
// words out. Valid/ready handshake. Depends on nothing.
interface rae_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_request;

	modport source(output valid, output in_byte, output end_of_request, input ready);
	modport sink(input valid, input in_byte, input end_of_request, output ready);
endinterface

interface rae_arg_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [7:0] arg_index;
	logic       last_in_arg;
	logic       empty_arg;
	logic       truncated;

	modport source(output valid, output payload_byte, output arg_index,
		output last_in_arg, output empty_arg, output truncated, input ready);
	modport sink(input valid, input payload_byte, input arg_index,
		input last_in_arg, input empty_arg, input truncated, output ready);
endinterface

// File: rtl/rae_front.sv
// Front end: takes request bytes, walks the RESP array framing and builds
// argument words. Depends on rae_pkg and rae_if.
module rae_front
	import rae_pkg::*;
#(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rae_req_if.sink     req,
	input  logic        q_full,
	output rae_push_t   push
);

	localparam int SUM_W = LEN_BITS + 4;
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

	rae_phase_t          phase_q, phase_d;
	logic [LEN_BITS-1:0] len_q, len_d;
	logic [LEN_BITS-1:0] left_q, left_d;
	logic [7:0]          cnt_q, cnt_d;

	logic                accept;
	logic                is_digit;
	logic [3:0]          digit;
	logic [SUM_W-1:0]    len_ext;
	logic [SUM_W-1:0]    len_sum;
	logic [LEN_BITS-1:0] len_sat;
	logic [LEN_BITS-1:0] left_dec;
	logic [7:0]          cnt_inc;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;

	assign is_digit = (req.in_byte >= CH_ZERO) && (req.in_byte <= CH_NINE);
	assign digit    = 4'(req.in_byte - CH_ZERO);
	assign len_ext  = {4'b0000, len_q};
	// len * 10 + digit, saturate at the all-ones length
	assign len_sum  = (len_ext << 3) + (len_ext << 1) + {{LEN_BITS{1'b0}}, digit};
	assign len_sat  = (|len_sum[SUM_W-1:LEN_BITS]) ? LEN_MAX : len_sum[LEN_BITS-1:0];
	assign left_dec = left_q - {{(LEN_BITS-1){1'b0}}, 1'b1};
	assign cnt_inc  = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		left_d  = left_q;
		cnt_d   = cnt_q;
		push.valid             = 1'b0;
		push.word.payload_byte = req.in_byte;
		push.word.arg_index    = cnt_q;
		push.word.last_in_arg  = 1'b0;
		push.word.empty_arg    = 1'b0;
		push.word.truncated    = 1'b0;

		case (phase_q)
			PH_STAR: begin
				phase_d = (req.in_byte == CH_STAR) ? PH_HEADER : PH_IDLE;
			end
			PH_HEADER: begin
				if (req.in_byte == CH_LF) begin
					phase_d = PH_DOLLAR;
				end
			end
			PH_DOLLAR: begin
				if (req.in_byte == CH_DOLLAR) begin
					len_d   = '0;
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					len_d = len_sat;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (len_q == '0) begin
					push.valid             = 1'b1;
					push.word.payload_byte = 8'h00;
					push.word.last_in_arg  = 1'b1;
					push.word.empty_arg    = 1'b1;
					cnt_d   = cnt_inc;
					phase_d = PH_TRAIL1;
				end else begin
					left_d  = len_q;
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				push.valid = 1'b1;
				left_d     = left_dec;
				if (left_dec == '0) begin
					push.word.last_in_arg = 1'b1;
					cnt_d   = cnt_inc;
					phase_d = PH_TRAIL1;
				end else if (req.end_of_request) begin
					push.word.last_in_arg = 1'b1;
					push.word.truncated   = 1'b1;
					cnt_d = cnt_inc;
				end
			end
			PH_TRAIL1: begin
				phase_d = PH_TRAIL2;
			end
			PH_TRAIL2: begin
				phase_d = PH_DOLLAR;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// end of request: drop all parse state after this byte
		if (req.end_of_request) begin
			phase_d = PH_STAR;
			len_d   = '0;
			left_d  = '0;
			cnt_d   = '0;
		end

		if (!accept) begin
			push.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STAR;
			len_q   <= '0;
			left_q  <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			left_q  <= left_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: rtl/rae_queue.sv
// Short word queue between the parser front end and the output stage.
// Depends on rae_pkg.
module rae_queue
	import rae_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  rae_push_t push,
	output logic      full,
	output logic      q_valid,
	output rae_word_t q_word,
	input  logic      pop
);

	rae_word_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_word  = mem_q[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/rae_back.sv
// Back end: output register that presents argument words on the result
// channel. Depends on rae_pkg and rae_if.
module rae_back
	import rae_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  rae_word_t q_word,
	output logic      pop,
	rae_arg_if.source arg
);

	logic      vld_q;
	rae_word_t word_q;

	// load when the register is empty or its word is taken this cycle
	assign pop = q_valid && (!vld_q || arg.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || arg.ready) begin
			vld_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= q_word;
		end
	end

	assign arg.valid        = vld_q;
	assign arg.payload_byte = word_q.payload_byte;
	assign arg.arg_index    = word_q.arg_index;
	assign arg.last_in_arg  = word_q.last_in_arg;
	assign arg.empty_arg    = word_q.empty_arg;
	assign arg.truncated    = word_q.truncated;

endmodule

// File: rtl/resp_array_argument_extractor_core.sv
// Takes one request byte per cycle on req and emits one word per payload
// byte of each bulk-string argument of a RESP array on arg, tagged with the
// argument index, a last flag, an empty-argument marker and a truncation
// flag. The parser updates its state once per accepted byte, so a byte is
// taken every cycle; req.ready drops only while the two-entry word queue
// is full because arg is stalled. A word goes from the word queue to the
// output register on arg. Header, length and trailer bytes give no word.
// Depends on rae_pkg, rae_if, rae_front, rae_queue and rae_back.
module resp_array_argument_extractor_core
	import rae_pkg::*;
#(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rae_req_if.sink   req,
	rae_arg_if.source arg
);

	rae_push_t push;
	logic      q_full;
	logic      q_valid;
	rae_word_t q_word;
	logic      pop;

	rae_front #(
		.LEN_BITS(LEN_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.push   (push)
	);

	rae_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (q_full),
		.q_valid (q_valid),
		.q_word  (q_word),
		.pop     (pop)
	);

	rae_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_word  (q_word),
		.pop     (pop),
		.arg     (arg)
	);

endmodule

// File: sim/tb_resp_array_argument_extractor_core.sv
`timescale 1ns / 100ps
// Testbench for resp_array_argument_extractor_core: streams RESP request bytes,
// mirrors the parser in a behavioral model and checks every argument word in order.
// Depends on rae_pkg, rae_if and the core RTL.
module tb_resp_array_argument_extractor_core
	import rae_pkg::*;
();

	localparam int LEN_BITS = LEN_BITS_DEF;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam int TOTAL_BYTES = 1600;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       eor;
	} req_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rae_req_if req();
	rae_arg_if arg();

	resp_array_argument_extractor_core #(.LEN_BITS(LEN_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.arg(arg)
	);

	req_byte_t   pending[$];
	req_byte_t   on_bus;
	rae_word_t   expected_words[$];
	logic [7:0]  msg[$];
	int          mismatches = 0;
	int unsigned cycle_cnt = 0;
	wire         calm = (cycle_cnt >= 400 && cycle_cnt < 900);

	// parser mirror
	rae_phase_t          phase;
	logic [LEN_BITS-1:0] len_acc;
	logic [LEN_BITS-1:0] bytes_rem;
	logic [7:0]          arg_cnt;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	function automatic void put_byte(input logic [7:0] b);
		msg.insert(msg.size(), b);
	endfunction

	function automatic void clear_parser();
		phase = PH_STAR;
		len_acc = '0;
		bytes_rem = '0;
		arg_cnt = '0;
	endfunction

	function automatic void close_arg();
		if (arg_cnt != 8'hFF)
			arg_cnt = arg_cnt + 8'd1;
	endfunction

	// advance the mirror by one byte and queue the word it yields, if any
	function automatic void parse_byte(input logic [7:0] b, input logic eor);
		rae_word_t       w;
		logic            has_word;
		longint unsigned acc;
		has_word = 1'b0;
		w = '0;
		w.arg_index = arg_cnt;
		case (phase)
		PH_STAR: begin
			phase = (b == CH_STAR) ? PH_HEADER : PH_IDLE;
		end
		PH_HEADER: begin
			if (b == CH_LF)
				phase = PH_DOLLAR;
		end
		PH_DOLLAR: begin
			if (b == CH_DOLLAR) begin
				len_acc = '0;
				phase = PH_DIGITS;
			end else begin
				phase = PH_IDLE;
			end
		end
		PH_DIGITS: begin
			if (b >= CH_ZERO && b <= CH_NINE) begin
				acc = 64'(len_acc) * 10 + 64'(b) - 64'(CH_ZERO);
				len_acc = (acc > 64'(LEN_MAX)) ? LEN_MAX : acc[LEN_BITS-1:0];
			end else begin
				phase = PH_SKIP;
			end
		end
		PH_SKIP: begin
			if (len_acc == '0) begin
				has_word = 1'b1;
				w.last_in_arg = 1'b1;
				w.empty_arg = 1'b1;
				close_arg();
				phase = PH_TRAIL1;
			end else begin
				bytes_rem = len_acc;
				phase = PH_PAYLOAD;
			end
		end
		PH_PAYLOAD: begin
			has_word = 1'b1;
			w.payload_byte = b;
			bytes_rem = bytes_rem - 1'b1;
			if (bytes_rem == '0) begin
				w.last_in_arg = 1'b1;
				close_arg();
				phase = PH_TRAIL1;
			end else if (eor) begin
				w.last_in_arg = 1'b1;
				w.truncated = 1'b1;
				close_arg();
			end
		end
		PH_TRAIL1: begin
			phase = PH_TRAIL2;
		end
		PH_TRAIL2: begin
			phase = PH_DOLLAR;
		end
		default: begin
			phase = PH_IDLE;
		end
		endcase
		if (has_word)
			expected_words.insert(expected_words.size(), w);
		if (eor)
			clear_parser();
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] v;
		v = 8'($urandom_range(255));
		while (v >= CH_ZERO && v <= CH_NINE)
			v = 8'($urandom_range(255));
		return v;
	endfunction

	function automatic void add_header(input int nargs, input bit tidy);
		string      s;
		logic [7:0] v;
		s = $sformatf("%0d", nargs);
		v = 8'($urandom_range(255));
		put_byte(CH_STAR);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
		if (!tidy && v != CH_LF)
			put_byte(v);
		put_byte(CH_CR);
		put_byte(CH_LF);
	endfunction

	// one bulk string; untidy framing uses random terminator, skip and trailer bytes
	function automatic void add_arg(input int len, input string digits, input bit tidy);
		put_byte(CH_DOLLAR);
		for (int i = 0; i < digits.len(); i++)
			put_byte(digits[i]);
		put_byte(tidy ? CH_CR : non_digit());
		put_byte(tidy ? CH_LF : 8'($urandom_range(255)));
		for (int i = 0; i < len; i++)
			put_byte(8'($urandom_range(255)));
		put_byte(tidy ? CH_CR : 8'($urandom_range(255)));
		put_byte(tidy ? CH_LF : 8'($urandom_range(255)));
	endfunction

	// queue the request up to and including byte stop, which carries end of request
	function automatic void send_msg(input int stop);
		for (int i = 0; i <= stop; i++)
			pending.insert(pending.size(), req_byte_t'{data: msg[i], eor: (i == stop)});
		msg.delete();
	endfunction

	function automatic void report(input string what, input rae_word_t want,
		input rae_word_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t %s: expected %h/%0d/%b%b%b, got %h/%0d/%b%b%b",
				$time, what, want.payload_byte, want.arg_index, want.last_in_arg,
				want.empty_arg, want.truncated, got.payload_byte, got.arg_index,
				got.last_in_arg, got.empty_arg, got.truncated);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready)
				parse_byte(on_bus.data, on_bus.eor);
			if (!req.valid || req.ready) begin
				if (pending.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
					on_bus = pending.pop_front();
					req.valid <= 1'b1;
					req.in_byte <= on_bus.data;
					req.end_of_request <= on_bus.eor;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// argument word monitor
	always @(posedge clk) begin
		rae_word_t got;
		rae_word_t want;
		got = {arg.payload_byte, arg.arg_index, arg.last_in_arg, arg.empty_arg, arg.truncated};
		if (!arst_n) begin
			arg.ready <= 1'b0;
		end else begin
			if (arg.valid && arg.ready) begin
				if (expected_words.size() == 0) begin
					report("unexpected word", '0, got);
				end else begin
					want = expected_words.pop_front();
					if (got !== want)
						report("word mismatch", want, got);
				end
			end
			arg.ready <= calm || $urandom_range(99) >= 16;
		end
	end

	initial begin
		int         kind;
		int         nargs;
		int         len;
		int         r;
		int         stop;
		int         idx;
		bit         tidy;
		bit         huge;
		string      digits;
		int         starts[$];

		req.valid = 1'b0;
		req.in_byte = 8'h00;
		req.end_of_request = 1'b0;
		arg.ready = 1'b0;
		clear_parser();

		// empty argument, then an oversized length cut off inside its payload
		put_byte(CH_STAR);
		put_byte(CH_LF);
		add_arg(0, "", 1'b1);
		add_arg(2, "2000000", 1'b1);
		send_msg(msg.size() - 3);
		// not an array
		put_byte(8'h41);
		send_msg(0);
		// payload extremes, then a missing dollar
		put_byte(CH_STAR);
		put_byte(CH_LF);
		add_arg(2, "2", 1'b1);
		msg[msg.size() - 4] = 8'h00;
		msg[msg.size() - 3] = 8'hFF;
		put_byte(8'h58);
		send_msg(msg.size() - 1);

		// enough arguments in one request to saturate the index; mostly empty ones
		add_header(262, 1'b1);
		for (int a = 0; a < 262; a++) begin
			if (a % 16 == 15)
				add_arg(1, "1", 1'b1);
			else
				add_arg(0, "", 1'b1);
		end
		send_msg(msg.size() - 1);

		while (pending.size() < TOTAL_BYTES) begin
			kind = $urandom_range(99);
			if (kind < 85) begin
				tidy = ($urandom_range(7) != 0);
				nargs = $urandom_range(1, 6);
				huge = 1'b0;
				starts.delete();
				add_header(nargs, tidy);
				for (int a = 0; a < nargs && !huge; a++) begin
					r = $urandom_range(99);
					if (r < 97) begin
						if (r < 30)
							len = $urandom_range(0, 2);
						else if (r < 90)
							len = $urandom_range(3, 8);
						else
							len = $urandom_range(9, 40);
						digits = (len == 0 && $urandom_range(1)) ? "" : $sformatf("%0d", len);
						if ($urandom_range(9) == 0)
							digits = {"0", digits};
					end else begin
						// saturating length: the request must end inside the payload
						huge = 1'b1;
						len = $urandom_range(1, 6);
						case ($urandom_range(2))
						0: digits = "1048575";
						1: digits = "1048576";
						default: digits = "987654321987";
						endcase
					end
					starts.insert(starts.size(), msg.size());
					add_arg(len, digits, tidy);
				end
				stop = huge ? msg.size() - 3 : msg.size() - 1;
				if (kind >= 70) begin
					// break it: end early, or spoil an element start
					if ($urandom_range(1)) begin
						stop = $urandom_range(0, stop);
					end else begin
						idx = starts[$urandom_range(0, starts.size() - 1)];
						msg[idx] = 8'($urandom_range(255));
						if (msg[idx] == CH_DOLLAR)
							msg[idx] = CH_STAR;
					end
				end
			end else begin
				repeat ($urandom_range(1, 12))
					put_byte(8'($urandom_range(255)));
				if ($urandom_range(2) == 0)
					msg[0] = CH_STAR;
				stop = msg.size() - 1;
			end
			send_msg(stop);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || req.valid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("tb_resp_array_argument_extractor_core: PASS");
		else
			$display("tb_resp_array_argument_extractor_core: FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_resp_array_argument_extractor_core: FAIL");
		$finish;
	end

endmodule
